FILE: rtl/mprq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath bundles of the priority ready queue.
package mprq_pkg;

  localparam int unsigned LEVELS_DEF      = 16;
  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned HANDLE_BITS_DEF = 8;

  localparam int unsigned PRIO_W   = 4;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;  // latch request, issue pointer reads
    logic look;    // issue entry reads for a dequeue
    logic commit;  // rewrite links and pointers, load result
  } cmd_t;

  typedef struct packed {
    logic empty;     // no level holds an entry
    logic out_free;  // result register can take a new beat
  } stat_t;

endpackage

FILE: rtl/mprq_chan_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the priority ready queue.
interface mprq_req_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [mprq_pkg::PRIO_W-1:0]       priority_req;
  logic [mprq_pkg::HANDLE_W-1:0]     task_handle;

  modport source (output valid, opcode, priority_req, task_handle, input ready);
  modport sink   (input valid, opcode, priority_req, task_handle, output ready);
endinterface

interface mprq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [mprq_pkg::STATUS_W-1:0]     status;
  logic [mprq_pkg::HANDLE_W-1:0]     out_handle;
  logic [mprq_pkg::PRIO_W-1:0]       out_priority;

  modport source (output valid, status, out_handle, out_priority, input ready);
  modport sink   (input valid, status, out_handle, out_priority, output ready);
endinterface

FILE: rtl/mprq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the priority ready queue: accept, optional entry lookup, commit.
module mprq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_opcode_i,
  input  mprq_pkg::stat_t  stat_i,
  output logic             req_ready_o,
  output mprq_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOK   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    req_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          // only a dequeue that finds an entry needs the second read
          if (req_opcode_i == mprq_pkg::OP_DEQ && !stat_i.empty) begin
            state_d = S_LOOK;
          end else begin
            state_d = S_COMMIT;
          end
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register is free
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/mprq_dp.sv
`timescale 1ns / 1ps
// Datapath of the priority ready queue: level pointers, linked entry store, free list.
module mprq_dp #(
  parameter int unsigned LEVELS      = mprq_pkg::LEVELS_DEF,
  parameter int unsigned CAPACITY    = mprq_pkg::CAPACITY_DEF,
  parameter int unsigned HANDLE_BITS = mprq_pkg::HANDLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mprq_pkg::cmd_t                    cmd_i,
  output mprq_pkg::stat_t                   stat_o,
  input  logic                              opcode_i,
  input  logic [mprq_pkg::PRIO_W-1:0]       priority_req_i,
  input  logic [mprq_pkg::HANDLE_W-1:0]     task_handle_i,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic [mprq_pkg::STATUS_W-1:0]     status_o,
  output logic [mprq_pkg::HANDLE_W-1:0]     out_handle_o,
  output logic [mprq_pkg::PRIO_W-1:0]       out_priority_o
);

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SB = (HANDLE_BITS < mprq_pkg::HANDLE_W) ? HANDLE_BITS
                                                                  : mprq_pkg::HANDLE_W;

  // storage
  logic [SB-1:0] handle_mem [CAPACITY];
  logic [AW-1:0] next_mem   [CAPACITY];
  logic [AW-1:0] head_mem   [LEVELS];
  logic [AW-1:0] tail_mem   [LEVELS];

  logic [LEVELS-1:0] nonempty_q, nonempty_d;
  logic [CW-1:0]     used_q, used_d;
  logic [CW-1:0]     fresh_q, fresh_d;
  logic [AW-1:0]     free_head_q, free_head_d;
  logic              rsp_valid_q, rsp_valid_d;

  // request and lookup registers
  logic          op_q;
  logic [LW-1:0] lvl_q;
  logic [SB-1:0] hnd_q;
  logic          recycled_q;
  logic [AW-1:0] alloc_q;
  logic          is_tail_q;

  logic [AW-1:0] head_rd_q, tail_rd_q, next_rd_q;
  logic [SB-1:0] handle_rd_q;

  logic [mprq_pkg::STATUS_W-1:0] status_q, status_d;
  logic [mprq_pkg::HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [mprq_pkg::PRIO_W-1:0]   out_prio_q, out_prio_d;

  logic [LW-1:0] enc_lvl, sat_lvl, lvl_sel;
  logic [31:0]   sat_w;
  logic          empty, full, recycled;
  logic          enq_ok, deq_ok;

  logic          next_we, next_re, head_we, tail_we, handle_we;
  logic [AW-1:0] next_waddr, next_wdata, next_raddr, head_wdata;

  // lowest-numbered non-empty level
  always_comb begin
    enc_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        enc_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    sat_w = (32'(priority_req_i) > 32'(LEVELS - 1)) ? 32'(LEVELS - 1)
                                                     : 32'(priority_req_i);
    sat_lvl = sat_w[LW-1:0];
    lvl_sel = (opcode_i == mprq_pkg::OP_DEQ) ? enc_lvl : sat_lvl;
  end

  assign empty    = (nonempty_q == '0);
  assign full     = (used_q == CW'(CAPACITY));
  assign recycled = (used_q != fresh_q);

  assign enq_ok = (op_q == mprq_pkg::OP_ENQ) && !full;
  assign deq_ok = (op_q == mprq_pkg::OP_DEQ) && !empty;

  assign stat_o.empty    = empty;
  assign stat_o.out_free = !rsp_valid_q || rsp_ready_i;

  // write controls, all at commit; next-pointer read at accept or look
  always_comb begin
    handle_we  = cmd_i.commit && enq_ok;
    tail_we    = cmd_i.commit && enq_ok;
    next_we    = cmd_i.commit && ((enq_ok && nonempty_q[lvl_q]) || deq_ok);
    head_we    = cmd_i.commit && ((enq_ok && !nonempty_q[lvl_q]) || (deq_ok && !is_tail_q));
    // enqueue links the old tail to the new entry; dequeue pushes the entry on the free list
    next_waddr = enq_ok ? tail_rd_q : head_rd_q;
    next_wdata = enq_ok ? alloc_q : free_head_q;
    head_wdata = enq_ok ? alloc_q : next_rd_q;
    next_re    = cmd_i.accept || cmd_i.look;
    next_raddr = cmd_i.look ? head_rd_q : free_head_q;
  end

  always_ff @(posedge clk_i) begin
    if (handle_we) begin
      handle_mem[alloc_q] <= hnd_q;
    end
    if (cmd_i.look) begin
      handle_rd_q <= handle_mem[head_rd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (next_re) begin
      next_rd_q <= next_mem[next_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[lvl_q] <= head_wdata;
    end
    if (cmd_i.accept) begin
      head_rd_q <= head_mem[lvl_sel];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_mem[lvl_q] <= alloc_q;
    end
    if (cmd_i.accept) begin
      tail_rd_q <= tail_mem[lvl_sel];
    end
  end

  // latch the request and pick the entry to allocate; note at lookup if the head is the tail
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= opcode_i;
      lvl_q      <= lvl_sel;
      hnd_q      <= task_handle_i[SB-1:0];
      recycled_q <= recycled;
      alloc_q    <= recycled ? free_head_q : fresh_q[AW-1:0];
    end
    if (cmd_i.look) begin
      is_tail_q <= (head_rd_q == tail_rd_q);
    end
  end

  always_comb begin
    nonempty_d   = nonempty_q;
    used_d       = used_q;
    fresh_d      = fresh_q;
    free_head_d  = free_head_q;
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    status_d     = status_q;
    out_handle_d = out_handle_q;
    out_prio_d   = out_prio_q;
    if (cmd_i.commit) begin
      rsp_valid_d  = 1'b1;
      out_handle_d = '0;
      out_prio_d   = '0;
      if (op_q == mprq_pkg::OP_ENQ) begin
        status_d = full ? mprq_pkg::ST_FULL : mprq_pkg::ST_ENQ;
      end else begin
        status_d = empty ? mprq_pkg::ST_EMPTY : mprq_pkg::ST_DEQ;
      end
      if (enq_ok) begin
        nonempty_d[lvl_q] = 1'b1;
        used_d            = used_q + CW'(1);
        if (recycled_q) begin
          free_head_d = next_rd_q;
        end else begin
          fresh_d = fresh_q + CW'(1);
        end
      end
      if (deq_ok) begin
        if (is_tail_q) begin
          nonempty_d[lvl_q] = 1'b0;
        end
        used_d       = used_q - CW'(1);
        free_head_d  = head_rd_q;
        out_handle_d = mprq_pkg::HANDLE_W'(handle_rd_q);
        out_prio_d   = mprq_pkg::PRIO_W'(lvl_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q  <= '0;
      used_q      <= '0;
      fresh_q     <= '0;
      free_head_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      nonempty_q  <= nonempty_d;
      used_q      <= used_d;
      fresh_q     <= fresh_d;
      free_head_q <= free_head_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    out_handle_q <= out_handle_d;
    out_prio_q   <= out_prio_d;
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign status_o       = status_q;
  assign out_handle_o   = out_handle_q;
  assign out_priority_o = out_prio_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_used_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= fresh_q)
    else $error("more entries in use than ever allocated");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty_q == '0) |-> (used_q == '0))
    else $error("all levels empty while entries are in use");

  a_commit_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> rsp_valid_q)
    else $error("commit did not present a result beat");
`endif

endmodule

FILE: rtl/multilevel_priority_ready_queue.sv
`timescale 1ns / 1ps
// Top level of the multilevel priority ready queue.
//
// Channels: req (sink) carries opcode, priority_req and task_handle; rsp (source)
// returns status, out_handle and out_priority. A beat moves when valid and ready
// are both high. Every request beat yields exactly one response beat, in order.
// An enqueue appends the handle to its level's FIFO (levels above LEVELS-1 use
// the last level); a dequeue pops the oldest handle of the lowest-numbered
// non-empty level, or answers empty. An enqueue into a full store answers full.
// Sequence: one item in flight. After the request beat, an enqueue, empty or full answer
// passes through the commit state, and a dequeue that finds an entry through the lookup
// and then the commit state; rsp.valid is registered from the commit, and req.ready
// returns in the same cycle as rsp.valid. The lookup state is due to the registered reads
// of the linked entry store: a dequeue reads the level head, then that entry.
// A stalled rsp holds its beat; req may still take one more request, whose
// result waits until the pending beat is taken.
// Reset: all levels empty, store free; no clearing pass, ready right after reset.
module multilevel_priority_ready_queue #(
  parameter int unsigned LEVELS      = mprq_pkg::LEVELS_DEF,
  parameter int unsigned CAPACITY    = mprq_pkg::CAPACITY_DEF,
  parameter int unsigned HANDLE_BITS = mprq_pkg::HANDLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mprq_req_if.sink   req,
  mprq_rsp_if.source rsp
);

  mprq_pkg::cmd_t  cmd;
  mprq_pkg::stat_t stat;

  mprq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req.valid),
    .req_opcode_i (req.opcode),
    .stat_i       (stat),
    .req_ready_o  (req.ready),
    .cmd_o        (cmd)
  );

  mprq_dp #(
    .LEVELS      (LEVELS),
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (req.opcode),
    .priority_req_i (req.priority_req),
    .task_handle_i  (req.task_handle),
    .rsp_ready_i    (rsp.ready),
    .rsp_valid_o    (rsp.valid),
    .status_o       (rsp.status),
    .out_handle_o   (rsp.out_handle),
    .out_priority_o (rsp.out_priority)
  );

endmodule
